FILE: rtl/mps_pkg.sv
package mps_pkg;

	// field widths
	localparam int POS_W  = 14;
	localparam int CODE_W = 8;
	localparam int SLOT_W = 5;
	localparam int RGB_W  = 24;
	localparam int ARGB_W = 32;
	localparam int CHAN_W = 8;
	localparam int PROD_W = 16;  // channel * shade factor
	localparam int SUM_W  = 15;  // weighted channel sum, at most 25500

	// defaults for top level parameters
	localparam int PALETTE_ENTRIES_DEF = 32;
	localparam int MAP_WIDTH_DEF       = 128;

	// color code layout
	localparam int IDX_MSB   = 6;
	localparam int IDX_LSB   = 2;
	localparam int IDX_W     = IDX_MSB - IDX_LSB + 1;
	localparam int CODE_HIGH = 7;  // set for codes of 128 and above

	// request commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// shade codes and factors
	localparam logic [1:0] SHADE_DARK   = 2'd0;
	localparam logic [1:0] SHADE_BRIGHT = 2'd2;
	localparam logic [7:0] FACTOR_DARK   = 8'd180;
	localparam logic [7:0] FACTOR_BRIGHT = 8'd255;
	localparam logic [7:0] FACTOR_NORMAL = 8'd220;

	// x / 255 for x < 2^16 as (x * 65794) >> 24
	localparam int RECIP255    = 65794;
	localparam int RECIP255_SH = 24;
	// x / 100 for x < 2^15 as (x * 41944) >> 22
	localparam int RECIP100    = 41944;
	localparam int RECIP100_SH = 22;

	// anaglyph mixing weights
	localparam int MIX_R  = 30;
	localparam int MIX_RG = 59;
	localparam int MIX_RB = 11;
	localparam int MIX_GB = 70;

	// alpha values
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_EVEN   = 8'd16;
	localparam logic [7:0] ALPHA_ODD    = 8'd24;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [PROD_W-1:0] r;
		logic [PROD_W-1:0] g;
		logic [PROD_W-1:0] b;
	} prod_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sum_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

FILE: rtl/mps_palette.sv
module mps_palette #(
	parameter int PALETTE_ENTRIES = mps_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                       clk,
	input  mps_pkg::stage_en_t         en,
	input  logic                       wr_en,
	input  logic [mps_pkg::SLOT_W-1:0] wr_slot,
	input  logic [mps_pkg::RGB_W-1:0]  wr_rgb,
	input  logic [mps_pkg::IDX_W-1:0]  rd_idx,
	output logic [mps_pkg::RGB_W-1:0]  base_s1
);
	import mps_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	logic [RGB_W-1:0] mem_q [PALETTE_ENTRIES];
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic             wr_ok;

	assign wr_addr = AW'(wr_slot);
	assign rd_addr = AW'(rd_idx);
	assign wr_ok   = wr_en && (int'(wr_slot) < PALETTE_ENTRIES);

	// write port, slots past the end are dropped
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_addr] <= wr_rgb;
		end
	end

	// registered read, held while stage 1 is stalled
	always_ff @(posedge clk) begin
		if (en.s1) begin
			base_s1 <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/mps_shade.sv
module mps_shade (
	input  logic                      clk,
	input  mps_pkg::stage_en_t        en,
	input  logic [mps_pkg::RGB_W-1:0] base_s1,
	input  logic [1:0]                shade_s1,
	output mps_pkg::rgb_t             chan_s3
);
	import mps_pkg::*;

	rgb_t        base;
	logic [7:0]  factor;
	prod_t       prod_s2;

	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W+16:0] p;
		p = (PROD_W+17)'(x) * (PROD_W+17)'(RECIP255);
		return p[RECIP255_SH+CHAN_W-1:RECIP255_SH];
	endfunction

	assign base = rgb_t'(base_s1);

	// shade factor from the low code bits
	always_comb begin
		case (shade_s1)
			SHADE_DARK:   factor = FACTOR_DARK;
			SHADE_BRIGHT: factor = FACTOR_BRIGHT;
			default:      factor = FACTOR_NORMAL;
		endcase
	end

	// stage 2: channel * factor
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2.r <= PROD_W'(base.r) * PROD_W'(factor);
			prod_s2.g <= PROD_W'(base.g) * PROD_W'(factor);
			prod_s2.b <= PROD_W'(base.b) * PROD_W'(factor);
		end
	end

	// stage 3: divide by 255
	always_ff @(posedge clk) begin
		if (en.s3) begin
			chan_s3.r <= div255(prod_s2.r);
			chan_s3.g <= div255(prod_s2.g);
			chan_s3.b <= div255(prod_s2.b);
		end
	end

endmodule

FILE: rtl/mps_mix.sv
module mps_mix (
	input  logic                       clk,
	input  mps_pkg::stage_en_t         en,
	input  logic                       anaglyph,
	input  mps_pkg::rgb_t              chan_s3,
	input  logic                       clear_s4,
	input  logic                       parity_s4,
	output logic [mps_pkg::ARGB_W-1:0] argb_s5
);
	import mps_pkg::*;

	sum_t sum_s4;
	rgb_t chan_s4;
	rgb_t mixed;

	function automatic logic [CHAN_W-1:0] div100(input logic [SUM_W-1:0] x);
		logic [SUM_W+15:0] p;
		p = (SUM_W+16)'(x) * (SUM_W+16)'(RECIP100);
		return p[RECIP100_SH+CHAN_W-1:RECIP100_SH];
	endfunction

	// stage 4: weighted sums for red-cyan mixing
	always_ff @(posedge clk) begin
		if (en.s4) begin
			chan_s4  <= chan_s3;
			sum_s4.r <= SUM_W'(chan_s3.r) * SUM_W'(MIX_R) + SUM_W'(chan_s3.g) * SUM_W'(MIX_RG)
				+ SUM_W'(chan_s3.b) * SUM_W'(MIX_RB);
			sum_s4.g <= SUM_W'(chan_s3.r) * SUM_W'(MIX_R) + SUM_W'(chan_s3.g) * SUM_W'(MIX_GB);
			sum_s4.b <= SUM_W'(chan_s3.r) * SUM_W'(MIX_R) + SUM_W'(chan_s3.b) * SUM_W'(MIX_GB);
		end
	end

	assign mixed.r = div100(sum_s4.r);
	assign mixed.g = div100(sum_s4.g);
	assign mixed.b = div100(sum_s4.b);

	// stage 5: final pixel
	always_ff @(posedge clk) begin
		if (en.s5) begin
			if (clear_s4) begin
				argb_s5 <= {(parity_s4 ? ALPHA_ODD : ALPHA_EVEN), {RGB_W{1'b0}}};
			end else if (anaglyph) begin
				argb_s5 <= {ALPHA_OPAQUE, mixed};
			end else begin
				argb_s5 <= {ALPHA_OPAQUE, chan_s4};
			end
		end
	end

endmodule

FILE: rtl/map_palette_shader.sv
// Pipeline: five register stages, s1 to s5; an accepted pixel request enters s1 and leaves from s5.
// Throughput: one request per cycle unless stalled; palette writes take one slot and give no result.
// The five stages advance independently, so bubbles close up while the output is stalled.
// Reset clears the stage valid bits and the anaglyph mode register.
// The palette is not cleared by reset; entries hold garbage until written.
module map_palette_shader #(
	parameter int PALETTE_ENTRIES = mps_pkg::PALETTE_ENTRIES_DEF,
	parameter int MAP_WIDTH       = mps_pkg::MAP_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [mps_pkg::POS_W-1:0]   pixel_index,
	input  logic [mps_pkg::CODE_W-1:0]  color_code,
	input  logic [mps_pkg::SLOT_W-1:0]  palette_slot,
	input  logic [mps_pkg::RGB_W-1:0]   palette_rgb,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mps_pkg::ARGB_W-1:0]  argb,
	output logic [mps_pkg::POS_W-1:0]   out_index
);
	import mps_pkg::*;

	// pos / MAP_WIDTH as (pos * DIV_M) >> DIV_SH, exact for all 14-bit pos
	localparam int DIV_L  = $clog2(MAP_WIDTH);
	localparam int DIV_SH = POS_W + DIV_L;
	localparam int DIV_M  = ((1 << DIV_SH) + MAP_WIDTH - 1) / MAP_WIDTH;
	localparam int DIV_PW = POS_W + 16;

	logic anaglyph_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	stage_en_t en;

	logic              accept;
	logic [IDX_W-1:0]  idx;
	logic              clear_in;

	logic [POS_W-1:0]  pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic [DIV_PW-1:0] divprod_s1;
	logic [1:0]        shade_s1;
	logic              clear_s1, clear_s2, clear_s3, clear_s4;
	logic              parity_s2, parity_s3, parity_s4;
	logic [RGB_W-1:0]  base_s1;
	rgb_t              chan_s3;
	logic [ARGB_W-1:0] argb_s5;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anaglyph_q <= 1'b0;
		end else if (cfg_wr_en) begin
			anaglyph_q <= cfg_wr_data;
		end
	end

	// each stage loads when it is empty or its successor moves
	assign rdy5 = !valid_s5 || !out_stall;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign en   = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	assign in_stall = !rdy1;
	assign accept   = in_valid && rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= accept && (cmd == CMD_PIXEL);
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// transparent: high codes, index zero, index past the palette
	assign idx      = color_code[IDX_MSB:IDX_LSB];
	assign clear_in = color_code[CODE_HIGH] || (idx == '0) || (int'(idx) >= PALETTE_ENTRIES);

	// sideband pipeline
	always_ff @(posedge clk) begin
		if (rdy1) begin
			pos_s1     <= pixel_index;
			divprod_s1 <= DIV_PW'(pixel_index) * DIV_PW'(DIV_M);
			shade_s1   <= color_code[1:0];
			clear_s1   <= clear_in;
		end
		if (rdy2) begin
			pos_s2    <= pos_s1;
			clear_s2  <= clear_s1;
			parity_s2 <= pos_s1[0] ^ divprod_s1[DIV_SH];
		end
		if (rdy3) begin
			pos_s3    <= pos_s2;
			clear_s3  <= clear_s2;
			parity_s3 <= parity_s2;
		end
		if (rdy4) begin
			pos_s4    <= pos_s3;
			clear_s4  <= clear_s3;
			parity_s4 <= parity_s3;
		end
		if (rdy5) begin
			pos_s5 <= pos_s4;
		end
	end

	mps_palette #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.en      (en),
		.wr_en   (accept && (cmd == CMD_WRITE)),
		.wr_slot (palette_slot),
		.wr_rgb  (palette_rgb),
		.rd_idx  (idx),
		.base_s1 (base_s1)
	);

	mps_shade u_shade (
		.clk      (clk),
		.en       (en),
		.base_s1  (base_s1),
		.shade_s1 (shade_s1),
		.chan_s3  (chan_s3)
	);

	mps_mix u_mix (
		.clk       (clk),
		.en        (en),
		.anaglyph  (anaglyph_q),
		.chan_s3   (chan_s3),
		.clear_s4  (clear_s4),
		.parity_s4 (parity_s4),
		.argb_s5   (argb_s5)
	);

	assign out_valid = valid_s5;
	assign argb      = argb_s5;
	assign out_index = pos_s5;

	// palette writes never enter the pipeline
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_WRITE) |=> !valid_s1)
		else $error("palette write produced a pipeline entry");

	// a pixel request enters stage 1 with its position
	a_pixel_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_PIXEL) |=> valid_s1 && (pos_s1 == $past(pixel_index)))
		else $error("pixel request lost at stage 1");

	// input stalls only with every stage full and the output blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall)
		else $error("input stalled with room in the pipeline");

	// non-opaque results are checkerboard pixels with no color
	a_clear_black: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && (argb_s5[ARGB_W-1:RGB_W] != ALPHA_OPAQUE) |-> (argb_s5[RGB_W-1:0] == '0))
		else $error("transparent pixel carries color");

endmodule

FILE: sim/map_palette_shader_test.sv
module map_palette_shader_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mps_pkg::*;

	localparam int SLOTS      = PALETTE_ENTRIES_DEF;
	localparam int ROW_PIXELS = MAP_WIDTH_DEF;
	localparam int MAX_WAIT   = 12;
	localparam int DRAIN_CYC  = 8;     // pipeline is 5 deep, palette writes give no result
	localparam int QUIET_MAX  = 2000;  // cycles with no handshake before giving up
	localparam int PHASE_REQS = 140;

	typedef struct {
		logic              cmd;
		logic [POS_W-1:0]  pos;
		logic [CODE_W-1:0] code;
		logic [SLOT_W-1:0] slot;
		logic [RGB_W-1:0]  rgb;
	} shade_req_t;

	typedef struct {
		logic [ARGB_W-1:0] argb;
		logic [POS_W-1:0]  pos;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_PIXEL;
	logic [POS_W-1:0] pixel_index = '0;
	logic [CODE_W-1:0] color_code = '0;
	logic [SLOT_W-1:0] palette_slot = '0;
	logic [RGB_W-1:0] palette_rgb = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ARGB_W-1:0] argb;
	logic [POS_W-1:0] out_index;

	map_palette_shader uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.pixel_index(pixel_index),
		.color_code(color_code),
		.palette_slot(palette_slot),
		.palette_rgb(palette_rgb),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.argb(argb),
		.out_index(out_index)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow state of the block
	logic [RGB_W-1:0] pal_mem [SLOTS];
	bit anaglyph_on = 1'b0;
	// slots written so far, tracked in generation order
	bit slot_loaded [SLOTS];

	shade_req_t req_queue [$];
	pixel_t due_pixels [$];
	int mismatches = 0;
	int quiet_cycles = 0;

	// expected ARGB for one color code at one map position
	function automatic logic [ARGB_W-1:0] shade_pixel(logic [CODE_W-1:0] code,
		logic [POS_W-1:0] pos);
		int unsigned idx, fac, base, r, g, b, nr, ng, nb, p;
		idx = code[IDX_MSB:IDX_LSB];
		p = pos;
		// transparent checkerboard for index zero and high codes
		if (code[CODE_HIGH] || idx == 0) begin
			return {((p + p / ROW_PIXELS) & 1) ? ALPHA_ODD : ALPHA_EVEN, 24'h0};
		end
		case (code[1:0])
			SHADE_DARK: fac = FACTOR_DARK;
			SHADE_BRIGHT: fac = FACTOR_BRIGHT;
			default: fac = FACTOR_NORMAL;
		endcase
		base = pal_mem[idx];
		r = ((base >> 16) & 8'hFF) * fac / 255;
		g = ((base >> 8) & 8'hFF) * fac / 255;
		b = (base & 8'hFF) * fac / 255;
		if (anaglyph_on) begin
			nr = (r * MIX_R + g * MIX_RG + b * MIX_RB) / 100;
			ng = (r * MIX_R + g * MIX_GB) / 100;
			nb = (r * MIX_R + b * MIX_GB) / 100;
			r = nr;
			g = ng;
			b = nb;
		end
		return {ALPHA_OPAQUE, r[7:0], g[7:0], b[7:0]};
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		if (mismatches < 10)
			$display("%s: expected %h, got %h", what, want, got);
		mismatches++;
	endfunction

	task automatic push_write(int slot, logic [RGB_W-1:0] rgb);
		shade_req_t q;
		q.cmd = CMD_WRITE;
		q.pos = POS_W'($urandom);
		q.code = CODE_W'($urandom);
		q.slot = SLOT_W'(slot);
		q.rgb = rgb;
		slot_loaded[slot] = 1'b1;
		req_queue.push_back(q);
	endtask

	task automatic push_pixel(logic [CODE_W-1:0] code, logic [POS_W-1:0] pos);
		shade_req_t q;
		q.cmd = CMD_PIXEL;
		q.pos = pos;
		q.code = code;
		q.slot = SLOT_W'($urandom);
		q.rgb = RGB_W'($urandom);
		req_queue.push_back(q);
	endtask

	// mostly colored pixels from loaded slots, some transparent codes and palette writes
	task automatic push_random(int count);
		int kind, s;
		logic [RGB_W-1:0] rgb;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				case ($urandom_range(0, 7))
					0: rgb = '0;
					1: rgb = '1;
					default: rgb = RGB_W'($urandom);
				endcase
				push_write($urandom_range(0, SLOTS - 1), rgb);
			end else if (kind < 25) begin
				push_pixel(CODE_W'($urandom_range(128, 255)), POS_W'($urandom));
			end else if (kind < 35) begin
				push_pixel({1'b0, 5'd0, 2'($urandom)}, POS_W'($urandom));
			end else begin
				do s = $urandom_range(1, SLOTS - 1); while (!slot_loaded[s]);
				push_pixel({1'b0, 5'(s), 2'($urandom)}, POS_W'($urandom));
			end
		end
	endtask

	// wait until every request is taken and every pixel is back, then let writes settle
	task automatic drain();
		while (req_queue.size() != 0 || in_valid || due_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic set_anaglyph(bit on);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= on;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		anaglyph_on = on;
	endtask

	// request driver
	shade_req_t cur_req;
	int gap_left = 0;
	bit in_rush = 1'b0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (cur_req.cmd == CMD_WRITE)
					pal_mem[cur_req.slot] = cur_req.rgb;
				else
					due_pixels.push_back('{shade_pixel(cur_req.code, cur_req.pos), cur_req.pos});
				if ($urandom_range(0, 49) == 0)
					in_rush = !in_rush;
				gap_left = in_rush ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (in_valid && in_stall) begin
				// hold the stalled request
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_queue.size() != 0) begin
				cur_req = req_queue.pop_front();
				cmd <= cur_req.cmd;
				pixel_index <= cur_req.pos;
				color_code <= cur_req.code;
				palette_slot <= cur_req.slot;
				palette_rgb <= cur_req.rgb;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// pixel monitor and output stall
	int hold_left = 0;
	bit out_rush = 1'b0;
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_pixels.size() == 0) begin
					note_mismatch("unexpected pixel", '0, argb);
				end else begin
					want = due_pixels.pop_front();
					if (argb !== want.argb)
						note_mismatch("argb", want.argb, argb);
					if (out_index !== want.pos)
						note_mismatch("out_index", 32'(want.pos), 32'(out_index));
				end
				if ($urandom_range(0, 49) == 0)
					out_rush = !out_rush;
				hold_left = out_rush ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_MAX)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		foreach (slot_loaded[i])
			slot_loaded[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		set_anaglyph(1'b0);

		// directed: color extremes, all shades, a write then a read of the same slot,
		// checkerboard parity, high codes
		push_write(31, 24'hFFFFFF);
		push_write(1, 24'h000000);
		push_write(16, 24'h808080);
		push_write(0, 24'h123456);
		push_pixel({1'b0, 5'd31, SHADE_DARK}, 14'd0);
		push_pixel({1'b0, 5'd31, 2'd1}, 14'd16383);
		push_pixel({1'b0, 5'd31, SHADE_BRIGHT}, 14'd1);
		push_pixel({1'b0, 5'd31, 2'd3}, 14'd127);
		push_pixel({1'b0, 5'd1, SHADE_BRIGHT}, 14'd128);
		push_pixel({1'b0, 5'd16, SHADE_DARK}, 14'd8191);
		push_write(2, RGB_W'($urandom));
		push_pixel({1'b0, 5'd2, SHADE_BRIGHT}, 14'd42);
		push_write(2, 24'hFFFFFF);
		push_pixel({1'b0, 5'd2, 2'd1}, 14'd43);
		push_pixel(8'h00, 14'd0);
		push_pixel(8'h03, 14'd1);
		push_pixel(8'h02, 14'd128);
		push_pixel(8'h01, 14'd16383);
		push_pixel(8'h80, 14'd255);
		push_pixel(8'hFF, 14'd5000);
		push_pixel(8'hFC, 14'd129);
		drain();

		// random phases across both mixing modes
		set_anaglyph(1'b1);
		push_random(PHASE_REQS);
		drain();
		set_anaglyph(1'b0);
		push_random(PHASE_REQS);
		drain();
		set_anaglyph(1'b1);
		push_random(PHASE_REQS);
		drain();
		set_anaglyph(1'b0);
		push_random(PHASE_REQS);
		drain();
		set_anaglyph(1'b1);
		push_random(PHASE_REQS);
		drain();
		push_random(PHASE_REQS);
		drain();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mps_pkg.sv
rtl/mps_palette.sv
rtl/mps_shade.sv
rtl/mps_mix.sv
rtl/map_palette_shader.sv
sim/map_palette_shader_test.sv
